FILE: src/lfu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache package
// Shared constants, controller state type and the command struct that the
// controller sends to the datapath.
// ----------------------------------------------------------------------------
package lfu_pkg;

    // Storage geometry.
    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int USED_W     = $clog2(ENTRIES + 1);

    // Field widths fixed by the interface.
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Entry mode codes.
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_SET = 1'b1;

    // Replacement search: entries are grouped, each group reduced in the
    // lookup cycle and the group winners reduced in the commit cycle.
    localparam int GROUP_SIZE = 8;
    localparam int GROUPS     = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int MKEY_W     = COUNT_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC
    } lfu_state_t;

    typedef struct packed {
        logic capture;   // latch the incoming item
        logic lookup;    // register match, free slot and group minima
        logic commit;    // update the entries and load the result
    } lfu_cmd_t;

endpackage

FILE: src/lfu_cache_top.sv
`timescale 1ns / 1ps
// Each item passes a lookup step, then a commit step that offers its result; a new item
// is accepted during the commit of the previous one, but not during its lookup. A
// waiting result stalls only the commit.
// Reset: all entries invalid and capacity 16, taking effect at once with no
// clearing pass; keys, values and counts are not reset.
// ----------------------------------------------------------------------------
// LFU cache top level
// Fully associative key/value store with least-frequently-used replacement.
// ----------------------------------------------------------------------------
module lfu_cache_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [63:0]               s_axis_tdata,  // key [31:0], write_value [63:32]
    input  logic                      s_axis_tuser,  // mode
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [31:0]               m_axis_tdata,  // read_value [31:0]
    output logic                      m_axis_tuser,  // hit
    input  logic                      cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);
    import lfu_pkg::*;

    lfu_cmd_t cmd;

    // Sequencing of each item.
    lfu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tvalid  (s_axis_tvalid),
        .in_tready  (s_axis_tready),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .cmd        (cmd)
    );

    // Storage, search and result.
    lfu_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_mode  (s_axis_tuser),
        .in_key   (s_axis_tdata[31:0]),
        .in_wval  (s_axis_tdata[63:32]),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_hit  (m_axis_tuser),
        .out_data (m_axis_tdata)
    );

endmodule

FILE: src/lfu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences each item through lookup and commit and owns the result valid
// flag, so that a new item is taken while the previous result waits.
// ----------------------------------------------------------------------------
module lfu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_tvalid,
    output logic             in_tready,
    output logic             out_tvalid,
    input  logic             out_tready,
    output lfu_pkg::lfu_cmd_t cmd
);
    import lfu_pkg::*;

    lfu_state_t state_reg;
    lfu_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       can_finish;
    logic       accept;

    // The result slot is free when empty or being taken this cycle.
    assign can_finish = !out_valid_reg || out_tready;
    assign in_tready  = (state_reg == ST_IDLE) || ((state_reg == ST_EXEC) && can_finish);
    assign accept     = in_tvalid && in_tready;
    assign out_tvalid = out_valid_reg;

    // State and result flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_tready;
        cmd            = '0;
        cmd.capture    = accept;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (can_finish)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = accept ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // An item is never taken in the middle of a lookup.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> !in_tready)
        else $error("item taken during lookup");

    // A commit always leaves a result waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit without result");

    // A commit never overwrites a result that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_tready))
        else $error("result overwritten");

    // An accepted item always goes on to a lookup.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOOKUP))
        else $error("accepted item not looked up");

endmodule

FILE: src/lfu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry storage, parallel key match, free slot and least-used search, entry
// update and the result register.
// ----------------------------------------------------------------------------
module lfu_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lfu_pkg::lfu_cmd_t         cmd,
    input  logic                      in_mode,
    input  logic [lfu_pkg::KEY_W-1:0] in_key,
    input  logic [lfu_pkg::VAL_W-1:0] in_wval,
    input  logic                      cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0] cfg_data,
    output logic                      out_hit,
    output logic [lfu_pkg::VAL_W-1:0] out_data
);
    import lfu_pkg::*;

    localparam int CMP_W = (CAP_W > USED_W) ? CAP_W : USED_W;

    // Item and configuration registers.
    logic                  mode_reg;
    logic [KEY_W-1:0]      ikey_reg;
    logic [VAL_W-1:0]      iwval_reg;
    logic [CAP_W-1:0]      cap_reg;

    // Entry storage.
    logic [ENTRIES-1:0]    valid_reg;
    logic [KEY_W-1:0]      key_reg [ENTRIES];
    logic [VAL_W-1:0]      val_reg [ENTRIES];
    logic [COUNT_BITS-1:0] cnt_reg [ENTRIES];

    // Lookup results.
    logic                  hit_reg;
    logic [IDX_W-1:0]      match_idx_reg;
    logic                  use_free_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic [MKEY_W-1:0]     grp_key_reg [GROUPS];
    logic [IDX_W-1:0]      grp_idx_reg [GROUPS];

    // Result register.
    logic                  out_hit_reg;
    logic [VAL_W-1:0]      out_data_reg;

    // Lookup logic.
    logic                  hit_next;
    logic [IDX_W-1:0]      match_idx_next;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx_next;
    logic [USED_W-1:0]     used;
    logic                  use_free_next;
    logic [MKEY_W-1:0]     grp_key_next [GROUPS];
    logic [IDX_W-1:0]      grp_idx_next [GROUPS];

    // Commit logic.
    logic [MKEY_W-1:0]     best_key;
    logic [IDX_W-1:0]      best_idx;
    logic [IDX_W-1:0]      slot;

    // Capture the item and the capacity register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= in_mode;
            ikey_reg  <= in_key;
            iwval_reg <= in_wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_data;
        end
    end

    // Key match, first free entry and occupancy.
    always_comb
    begin
        hit_next       = 1'b0;
        match_idx_next = '0;
        free_found     = 1'b0;
        free_idx_next  = '0;
        used           = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (key_reg[i] == ikey_reg))
            begin
                hit_next       = 1'b1;
                match_idx_next = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_found    = 1'b1;
                free_idx_next = IDX_W'(i);
            end
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            used = used + USED_W'(valid_reg[i]);
        end
        // A capacity of zero behaves as one; any free entry means used < ENTRIES.
        if (cap_reg == '0)
        begin
            use_free_next = free_found && (used == '0);
        end
        else
        begin
            use_free_next = free_found && (CMP_W'(used) < CMP_W'(cap_reg));
        end
    end

    // Least-used candidate of each group; invalid entries sort last.
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_key_next[g] = {MKEY_W{1'b1}};
            grp_idx_next[g] = IDX_W'(g * GROUP_SIZE);
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if ((g * GROUP_SIZE + j) < ENTRIES)
                begin
                    if ({!valid_reg[g * GROUP_SIZE + j], cnt_reg[g * GROUP_SIZE + j]}
                        < grp_key_next[g])
                    begin
                        grp_key_next[g] = {!valid_reg[g * GROUP_SIZE + j],
                                           cnt_reg[g * GROUP_SIZE + j]};
                        grp_idx_next[g] = IDX_W'(g * GROUP_SIZE + j);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg       <= hit_next;
            match_idx_reg <= match_idx_next;
            use_free_reg  <= use_free_next;
            free_idx_reg  <= free_idx_next;
            for (int g = 0; g < GROUPS; g++)
            begin
                grp_key_reg[g] <= grp_key_next[g];
                grp_idx_reg[g] <= grp_idx_next[g];
            end
        end
    end

    // Final least-used winner and target slot of a set.
    always_comb
    begin
        best_key = grp_key_reg[0];
        best_idx = grp_idx_reg[0];
        for (int g = 1; g < GROUPS; g++)
        begin
            if (grp_key_reg[g] < best_key)
            begin
                best_key = grp_key_reg[g];
                best_idx = grp_idx_reg[g];
            end
        end
        if (hit_reg)
        begin
            slot = match_idx_reg;
        end
        else if (use_free_reg)
        begin
            slot = free_idx_reg;
        end
        else
        begin
            slot = best_idx;
        end
    end

    // Entry update on commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.commit && (mode_reg == MODE_SET))
        begin
            valid_reg[slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (mode_reg == MODE_SET)
            begin
                key_reg[slot] <= ikey_reg;
                val_reg[slot] <= iwval_reg;
                cnt_reg[slot] <= COUNT_ONE;
            end
            else if (hit_reg && (cnt_reg[match_idx_reg] != COUNT_MAX))
            begin
                cnt_reg[match_idx_reg] <= cnt_reg[match_idx_reg] + COUNT_ONE;
            end
        end
    end

    // Result register: only a get hit returns data.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg  <= (mode_reg == MODE_GET) && hit_reg;
            out_data_reg <= ((mode_reg == MODE_GET) && hit_reg) ? val_reg[match_idx_reg] : '0;
        end
    end

    assign out_hit  = out_hit_reg;
    assign out_data = out_data_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU cache testbench
// Drives get and set items through the stream input, keeps a mirror of the
// cache contents and use counts, and compares every returned item with the
// reply that the mirror predicts. Directed cases cover field extremes and
// capacity corners, then random traffic runs over several capacities with
// idling on both sides, a long output hold-off and a heavily used entry run.
// ----------------------------------------------------------------------------
module tb_top;
    import lfu_pkg::*;

    // One predicted reply: hit flag and read value.
    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
    } cache_reply_t;

    // Length of the long output hold-off, in cycles.
    localparam int HOLD_CYCLES = 400;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [63:0]      s_axis_tdata;   // key [31:0], write_value [63:32]
    logic             s_axis_tuser;   // mode
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [31:0]      m_axis_tdata;   // read_value [31:0]
    logic             m_axis_tuser;   // hit
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_data;

    // Mirror of the cache contents.
    logic                  mirror_valid [ENTRIES];
    logic [KEY_W-1:0]      mirror_key   [ENTRIES];
    logic [VAL_W-1:0]      mirror_value [ENTRIES];
    logic [COUNT_BITS-1:0] mirror_count [ENTRIES];
    logic [CAP_W-1:0]      mirror_capacity;

    cache_reply_t pending_replies[$];
    int           error_count   = 0;
    bit           tx_idle_en    = 1'b1;
    bit           rx_idle_en    = 1'b1;
    bit           hold_request  = 1'b0;

    lfu_cache_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one item to the mirror and returns the reply it should produce.
    function automatic cache_reply_t apply_request(input logic mode,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] wval);
        cache_reply_t reply;
        int           slot;
        int           free_slot;
        int           used;
        int           best;
        int           cap;
        int           i;
        reply.hit   = 1'b0;
        reply.value = '0;
        slot        = -1;
        for (i = 0; i < ENTRIES; i++)
            if (slot < 0 && mirror_valid[i] && mirror_key[i] == key)
                slot = i;

        if (mode == MODE_GET)
        begin
            if (slot >= 0)
            begin
                reply.hit   = 1'b1;
                reply.value = mirror_value[slot];
                if (mirror_count[slot] != COUNT_MAX)
                    mirror_count[slot] = mirror_count[slot] + 1'b1;
            end
            return reply;
        end

        // A new key takes the lowest free entry while below capacity, or else the least-used one.
        if (slot < 0)
        begin
            cap = mirror_capacity;
            if (cap == 0)
                cap = 1;
            if (cap > ENTRIES)
                cap = ENTRIES;
            used      = 0;
            free_slot = -1;
            for (i = 0; i < ENTRIES; i++)
            begin
                if (mirror_valid[i])
                    used++;
                else if (free_slot < 0)
                    free_slot = i;
            end
            if (used < cap && free_slot >= 0)
                slot = free_slot;
            else
            begin
                best = -1;
                for (i = 0; i < ENTRIES; i++)
                    if (mirror_valid[i] && (best < 0 || mirror_count[i] < mirror_count[best]))
                        best = i;
                slot = (best >= 0) ? best : 0;
            end
        end
        mirror_valid[slot] = 1'b1;
        mirror_key[slot]   = key;
        mirror_value[slot] = wval;
        mirror_count[slot] = COUNT_ONE;
        return reply;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Output side: compare every accepted item with the oldest prediction.
    always @(posedge clk)
    begin : reply_check
        cache_reply_t want;
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (pending_replies.size() == 0)
                flag_error($sformatf("unexpected reply hit=%b value=%h",
                                     m_axis_tuser, m_axis_tdata));
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tuser !== want.hit || m_axis_tdata !== want.value)
                    flag_error($sformatf("reply expected hit=%b value=%h, got hit=%b value=%h",
                                         want.hit, want.value, m_axis_tuser, m_axis_tdata));
            end
        end
    end

    // Output side readiness: random stalls and the long hold-off on request.
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left    = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left    = $urandom_range(1, 4) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offers one item, predicts its reply on acceptance, then maybe idles.
    task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] wval);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {wval, key};
        s_axis_tuser  <= mode;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        pending_replies.push_back(apply_request(mode, key, wval));
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Waits until every predicted reply has arrived and the block is quiet.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        mirror_capacity = cap;
        cfg_we <= 1'b0;
    endtask

    // Gets straight after reset miss, whatever the write value.
    task automatic test_reset_state();
        send_request(MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // Extreme keys and values, overwrite of a stored key, ignored write value.
    task automatic test_field_extremes();
        send_request(MODE_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(MODE_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(MODE_SET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(MODE_GET, 32'h0000_0000, 32'h1234_5678);
        send_request(MODE_SET, 32'h0000_0000, 32'h0000_0001);
        send_request(MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(MODE_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Capacity lowered below the valid count, capacity zero and above range.
    task automatic test_capacity_corners();
        write_capacity(CAP_W'(2));
        send_request(MODE_SET, 32'h1111_1111, 32'hA5A5_A5A5);
        send_request(MODE_GET, 32'h1111_1111, 32'h0);
        send_request(MODE_GET, 32'h7FFF_FFFF, 32'h0);
        send_request(MODE_GET, 32'h8000_0000, 32'h0);
        send_request(MODE_GET, 32'h0000_0000, 32'h0);
        write_capacity(CAP_W'(0));
        send_request(MODE_SET, 32'h2222_2222, 32'h5A5A_5A5A);
        send_request(MODE_GET, 32'h2222_2222, 32'h0);
        write_capacity(CAP_W'(31));
        send_request(MODE_SET, 32'h3333_3333, 32'hC3C3_C3C3);
        send_request(MODE_SET, 32'h4444_4444, 32'h3C3C_3C3C);
        send_request(MODE_GET, 32'h3333_3333, 32'h0);
        write_capacity(CAP_W'(16));
    endtask

    // The output holds off for a long stretch while items keep coming.
    task automatic test_input_stall();
        int i;
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        hold_request = 1'b1;
        for (i = 0; i < 24; i++)
            send_request(i[0] ? MODE_SET : MODE_GET, 32'hA5A5_0000 + (i % 6), $urandom());
        wait_idle();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Random gets and sets over a small key pool at one capacity setting.
    task automatic test_random_traffic(input int n_items, input logic [CAP_W-1:0] cap,
                                       input bit idle);
        logic [KEY_W-1:0] pool [24];
        logic [KEY_W-1:0] key;
        int               pool_size;
        int               eff;
        int               pick;
        int               i;
        write_capacity(cap);
        tx_idle_en = idle;
        rx_idle_en = idle;
        eff        = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : int'(cap));
        pool_size  = eff + $urandom_range(1, 8);
        for (i = 0; i < pool_size; i++)
            pool[i] = $urandom();
        if ($urandom_range(0, 1))
            pool[0] = 32'h7FFF_FFFF;
        if ($urandom_range(0, 1))
            pool[1] = 32'h8000_0000;

        for (i = 0; i < n_items; i++)
        begin
            // Skew towards low pool indexes so use counts differ.
            pick = $urandom_range(0, pool_size - 1);
            if ($urandom_range(0, 1))
                pick = pick % ($urandom_range(1, pool_size));
            key = ($urandom_range(0, 9) == 0) ? $urandom() : pool[pick];
            send_request(($urandom_range(0, 99) < 45) ? MODE_SET : MODE_GET, key, $urandom());
        end
    endtask

    // A heavily used entry keeps a high count and survives evictions.
    task automatic test_hot_entry();
        logic [KEY_W-1:0] hot_key;
        int               i;
        write_capacity(CAP_W'(16));
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hot_key    = 32'h5A5A_C3C3;
        send_request(MODE_SET, hot_key, 32'hDEAD_BEEF);
        for (i = 0; i < 40; i++)
            send_request(MODE_GET, hot_key, 32'h0);
        for (i = 0; i < 17; i++)
            send_request(MODE_SET, 32'h0BAD_0000 + i, $urandom());
        send_request(MODE_GET, hot_key, 32'h0);
        for (i = 0; i < 3; i++)
            send_request(MODE_GET, hot_key, 32'h0);
        for (i = 0; i < 17; i++)
            send_request(MODE_SET, 32'h0CAB_0000 + i, $urandom());
        send_request(MODE_GET, hot_key, 32'h0);
    endtask

    // Reset, test sequence and final verdict.
    initial
    begin
        int i;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        for (i = 0; i < ENTRIES; i++)
        begin
            mirror_valid[i] = 1'b0;
            mirror_key[i]   = '0;
            mirror_value[i] = '0;
            mirror_count[i] = '0;
        end
        mirror_capacity = CAP_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_field_extremes();
        test_capacity_corners();
        test_input_stall();
        test_random_traffic(220, CAP_W'(16), 1'b1);
        test_random_traffic(220, CAP_W'(1), 1'b1);
        test_random_traffic(220, CAP_W'(0), 1'b1);
        test_random_traffic(220, CAP_W'(31), 1'b1);
        test_random_traffic(220, CAP_W'(17), 1'b1);
        test_random_traffic(220, CAP_W'(3), 1'b1);
        test_random_traffic(220, CAP_W'($urandom_range(0, 31)), 1'b1);
        test_hot_entry();
        test_random_traffic(220, CAP_W'(8), 1'b0);
        wait_idle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Run limit.
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
src/lfu_pkg.sv
src/lfu_ctrl.sv
src/lfu_datapath.sv
src/lfu_cache_top.sv
tb/tb_top.sv
